FILE: rtl/sl_pkg.sv
`timescale 1ns / 1ps

package sl_pkg;

	typedef enum logic [3:0] {
		KIND_ASSIGN  = 4'd0,
		KIND_PLUS    = 4'd1,
		KIND_LPAREN  = 4'd2,
		KIND_RPAREN  = 4'd3,
		KIND_LBRACE  = 4'd4,
		KIND_RBRACE  = 4'd5,
		KIND_SEMI    = 4'd6,
		KIND_INT     = 4'd7,
		KIND_LITERAL = 4'd8,
		KIND_IDENT   = 4'd9
	} kind_t;

	localparam logic [7:0] CH_ASSIGN = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [2:0]  KW_LEN    = 3'd3;
	localparam logic [2:0]  KW_FAILED = 3'd4;
	localparam logic [15:0] LEN_MAX   = 16'hFFFF;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [15:0] length;
	} token_t;

	// One queue entry holds every token caused by one input character.
	typedef struct packed {
		token_t tok0;
		token_t tok1;
		logic   two;
	} entry_t;

	function automatic logic [7:0] kw_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0:    ch = 8'h69;
			2'd1:    ch = 8'h6E;
			2'd2:    ch = 8'h74;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: rtl/sl_front.sv
`timescale 1ns / 1ps

module sl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      char_code,
	input  logic            end_of_input,
	input  logic            queue_full,
	output logic            push,
	output sl_pkg::entry_t  push_entry
);
	import sl_pkg::*;

	logic [31:0] pos_q;
	logic [15:0] len_q;
	logic [31:0] start_q;
	logic [7:0]  first_q;
	logic [2:0]  kp_q;
	logic        digits_q;

	logic   accept;
	logic   pending;
	logic   is_sym;
	logic   is_space;
	kind_t  sym_kind;
	kind_t  word_kind;
	token_t word_tok;
	token_t sym_tok;
	logic   kw_step;

	assign in_stall = queue_full;
	assign accept   = in_valid & ~queue_full;
	assign pending  = (len_q != 16'd0);

	always_comb begin
		is_sym   = 1'b1;
		sym_kind = KIND_ASSIGN;
		case (char_code)
			CH_ASSIGN: sym_kind = KIND_ASSIGN;
			CH_LPAREN: sym_kind = KIND_LPAREN;
			CH_RPAREN: sym_kind = KIND_RPAREN;
			CH_SEMI:   sym_kind = KIND_SEMI;
			default:   is_sym = 1'b0;
		endcase
	end

	assign is_space = (char_code == CH_SPACE) || (char_code inside {[CH_TAB:CH_CR]});

	always_comb begin
		if (first_q == CH_PLUS) begin
			word_kind = KIND_PLUS;
		end else if (first_q == CH_LBRACE) begin
			word_kind = KIND_LBRACE;
		end else if (first_q == CH_RBRACE) begin
			word_kind = KIND_RBRACE;
		end else if (len_q == 16'd3 && kp_q == KW_LEN) begin
			word_kind = KIND_INT;
		end else if (digits_q) begin
			word_kind = KIND_LITERAL;
		end else begin
			word_kind = KIND_IDENT;
		end
	end

	assign word_tok = '{kind: word_kind, start: start_q, length: len_q};
	assign sym_tok  = '{kind: sym_kind, start: pos_q, length: 16'd1};

	assign kw_step = (kp_q < KW_LEN) && ({13'd0, kp_q} == len_q) &&
		(char_code == kw_char(kp_q[1:0]));

	always_comb begin
		push       = 1'b0;
		push_entry = '{tok0: word_tok, tok1: sym_tok, two: 1'b0};
		if (accept) begin
			if (end_of_input) begin
				push = pending;
			end else if (is_sym || is_space) begin
				push = pending | is_sym;
				push_entry.two = pending & is_sym;
				if (!pending) begin
					push_entry.tok0 = sym_tok;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 32'd0;
			len_q    <= 16'd0;
			start_q  <= 32'd0;
			first_q  <= 8'd0;
			kp_q     <= 3'd0;
			digits_q <= 1'b1;
		end else if (accept) begin
			if (end_of_input || is_sym || is_space) begin
				len_q    <= 16'd0;
				start_q  <= 32'd0;
				first_q  <= 8'd0;
				kp_q     <= 3'd0;
				digits_q <= 1'b1;
			end else begin
				if (!pending) begin
					start_q <= pos_q;
					first_q <= char_code;
				end
				kp_q <= kw_step ? kp_q + 3'd1 : KW_FAILED;
				if (char_code < CH_ZERO || char_code > CH_NINE) begin
					digits_q <= 1'b0;
				end
				if (len_q != LEN_MAX) begin
					len_q <= len_q + 16'd1;
				end
			end
			// end of input consumes no position
			if (!end_of_input) begin
				pos_q <= pos_q + 32'd1;
			end
		end
	end

endmodule

FILE: rtl/sl_queue.sv
`timescale 1ns / 1ps

module sl_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sl_pkg::entry_t  push_entry,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output sl_pkg::entry_t  head_entry
);
	import sl_pkg::*;

	// DEPTH must be a power of two, at least 2, so the pointers wrap naturally; the block does not enforce this.
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/sl_back.sv
`timescale 1ns / 1ps

module sl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  sl_pkg::entry_t  head_entry,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [3:0]      token_kind,
	output logic [31:0]     token_start,
	output logic [15:0]     token_length,
	output logic            last_of_run
);
	import sl_pkg::*;

	logic   out_valid_q;
	logic   second_q;
	token_t tok_q;
	logic   last_q;

	logic   load;
	logic   split_first;

	assign load        = head_valid && (!out_valid_q || !out_stall);
	// hold the entry for a second transaction when it carries two tokens
	assign split_first = head_entry.two && !second_q;
	assign pop         = load && !split_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= split_first;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= second_q ? head_entry.tok1 : head_entry.tok0;
			last_q <= !split_first;
		end
	end

	assign out_valid    = out_valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.length;
	assign last_of_run  = last_q;

endmodule

FILE: rtl/separator_lexer_top.sv
`timescale 1ns / 1ps
// A token enters the queue when the character that closes it is accepted, then is registered at the output.
// Throughput: one character per cycle; a character that both ends a word and is a
// symbol yields two tokens, which leave as two output transactions from one queue entry.
// Input stalls only when the QUEUE_DEPTH-entry queue between front and back is full.
// Reset clears position, pending word, queue and output valid; no clearing pass.

module separator_lexer_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [31:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);
	import sl_pkg::*;

	logic   push;
	logic   pop;
	logic   full;
	logic   head_valid;
	entry_t push_entry;
	entry_t head_entry;

	sl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.queue_full   (full),
		.push         (push),
		.push_entry   (push_entry)
	);

	sl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	sl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule

FILE: rtl/sl_checker.sv
`timescale 1ns / 1ps

module sl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  char_code,
	input logic        end_of_input,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  token_kind,
	input logic [31:0] token_start,
	input logic [15:0] token_length,
	input logic        last_of_run
);
	import sl_pkg::*;

	logic sym_out;

	assign sym_out = out_valid && (token_kind == KIND_ASSIGN || token_kind == KIND_LPAREN ||
		token_kind == KIND_RPAREN || token_kind == KIND_SEMI);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(char_code) && $stable(end_of_input))
		else $error("stalled input transaction changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) &&
		$stable(token_start) && $stable(token_length) && $stable(last_of_run))
		else $error("stalled output transaction changed");

	a_sym_shape: assert property (@(posedge clk) disable iff (!arst_n)
		sym_out |-> token_length == 16'd1 && last_of_run)
		else $error("symbol token not single and last");

	a_len_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_length != 16'd0 && token_kind <= KIND_IDENT)
		else $error("empty token or bad kind");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run)
		else $error("second token of a pair did not follow");

endmodule

bind separator_lexer_top sl_checker u_sl_checker (.*);
